>>> design/fvkxc_pkg.sv
// fvkxc_pkg: shared types, constants and helpers for the keystream xor cipher
// no dependencies; imported by fvkxc_cfg_regs, fvkxc_keygen and the top level

package fvkxc_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 64;
	localparam int KEY_BITS       = 128;
	localparam int STATE_BITS     = 64;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_VARIANT  = 2'd2;

	// generator selection
	typedef enum logic [1:0] {
		VAR_ROLL     = 2'd0,
		VAR_LCG      = 2'd1,
		VAR_MUL31    = 2'd2,
		VAR_XORSHIFT = 2'd3
	} variant_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		variant_t            variant;
	} cfg_t;

	// generator constants
	localparam logic [7:0]  SEED_ROLL_XOR  = 8'hA5;
	localparam logic [7:0]  ROLL_OUT_XOR   = 8'h5A;
	localparam logic [31:0] SEED_LCG_XOR   = 32'hC3A5C85C;
	localparam logic [31:0] LCG_MUL        = 32'd1664525;
	localparam logic [31:0] LCG_ADD        = 32'd1013904223;
	localparam logic [7:0]  ROLL_POS_MUL   = 8'd13;
	localparam logic [7:0]  LCG_POS_MUL    = 8'd7;
	localparam logic [7:0]  MUL31_FACTOR   = 8'd31;
	localparam logic [3:0]  XS_POS_MUL     = 4'd3;
	localparam int          XS_SHIFT_A     = 13;
	localparam int          XS_SHIFT_B     = 7;
	localparam int          XS_SHIFT_C     = 17;

	// key byte idx of the 128-bit key, byte 0 in bits 7:0
	function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] key,
			input logic [3:0] idx);
		return key[{idx, 3'b000} +: 8];
	endfunction

endpackage

>>> design/fvkxc_cfg_regs.sv
// fvkxc_cfg_regs: key and variant registers behind the plain write port
// depends on fvkxc_pkg

module fvkxc_cfg_regs
	import fvkxc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	variant_t    variant_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			variant_q  <= VAR_ROLL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_VARIANT:  variant_q  <= variant_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	assign cfg.key     = {key_high_q, key_low_q};
	assign cfg.variant = variant_q;

endmodule

>>> design/fvkxc_keygen.sv
// fvkxc_keygen: seeding and one keystream step for all four generators
// depends on fvkxc_pkg; purely combinational, sits between the input and result registers

module fvkxc_keygen
	import fvkxc_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  cfg_t                     cfg,
	input  logic                     seed_now,
	input  logic [STATE_BITS-1:0]    gen_state,
	input  logic [POSITION_BITS-1:0] pos,
	input  logic [31:0]              fid,
	output logic [7:0]               ks_byte,
	output logic [STATE_BITS-1:0]    gen_next
);

	logic [63:0]          pos64;
	logic [STATE_BITS-1:0] seed_val;
	logic [STATE_BITS-1:0] cur;
	logic [7:0]           kb0;
	logic [7:0]           kb1;
	logic [7:0]           kb7;
	logic [7:0]           kb_pos;
	logic [7:0]           kb_sum;
	logic [7:0]           kb_tri;
	logic [7:0]           roll;

	// rolling-byte mix
	logic [7:0]  v0_mix;
	logic [7:0]  v0_k;
	// lcg
	logic [31:0] v1_s;
	logic [7:0]  v1_mix;
	logic [7:0]  v1_k;
	// multiply-by-31 roll
	logic [7:0]  v2_k;
	logic [7:0]  v2_roll;
	// xorshift with feedback
	logic [63:0] xs_a;
	logic [63:0] xs_b;
	logic [63:0] xs_c;
	logic [63:0] xs_sh;
	logic [7:0]  v3_k;

	assign pos64 = 64'(pos);

	assign kb0    = key_byte(cfg.key, 4'd0);
	assign kb1    = key_byte(cfg.key, 4'd1);
	assign kb7    = key_byte(cfg.key, 4'd7);
	assign kb_pos = key_byte(cfg.key, pos64[3:0]);
	assign kb_sum = key_byte(cfg.key, 4'(pos64[3:0] + fid[3:0]));
	assign kb_tri = key_byte(cfg.key, 4'(pos64[3:0] * XS_POS_MUL + fid[3:0]));

	always_comb begin
		unique case (cfg.variant)
			VAR_ROLL:     seed_val = {56'd0, fid[7:0] ^ kb0 ^ SEED_ROLL_XOR};
			VAR_LCG:      seed_val = {32'd0, fid ^ SEED_LCG_XOR};
			VAR_MUL31:    seed_val = {56'd0, kb7 ^ fid[7:0]};
			VAR_XORSHIFT: seed_val = {kb0, kb1, 16'd0, fid};
			default:      seed_val = '0;
		endcase
	end

	assign cur  = seed_now ? seed_val : gen_state;
	assign roll = cur[7:0];

	assign v0_mix = 8'(pos64[7:0] * ROLL_POS_MUL + fid[7:0]);
	assign v0_k   = kb_pos ^ roll ^ v0_mix;

	assign v1_s   = 32'(cur[31:0] * LCG_MUL + LCG_ADD + 32'(kb_pos));
	assign v1_mix = 8'(pos64[7:0] * LCG_POS_MUL + fid[7:0]);
	assign v1_k   = v1_s[31:24] ^ v1_mix;

	assign v2_k    = 8'(kb_sum + roll + pos64[9:2]);
	assign v2_roll = 8'(roll * MUL31_FACTOR + v2_k) ^ kb_pos;

	assign xs_a  = cur ^ (cur << XS_SHIFT_A);
	assign xs_b  = xs_a ^ (xs_a >> XS_SHIFT_B);
	assign xs_c  = xs_b ^ (xs_b << XS_SHIFT_C);
	assign xs_sh = xs_c >> pos64[2:0];
	assign v3_k  = xs_sh[7:0] ^ kb_tri;

	always_comb begin
		unique case (cfg.variant)
			VAR_ROLL: begin
				ks_byte  = v0_k;
				gen_next = {56'd0, 8'(roll + v0_k) ^ ROLL_OUT_XOR};
			end
			VAR_LCG: begin
				ks_byte  = v1_k;
				gen_next = {32'd0, v1_s};
			end
			VAR_MUL31: begin
				ks_byte  = v2_k;
				gen_next = {56'd0, v2_roll};
			end
			VAR_XORSHIFT: begin
				ks_byte  = v3_k;
				gen_next = xs_c + 64'(v3_k) + pos64;
			end
			default: begin
				ks_byte  = '0;
				gen_next = '0;
			end
		endcase
	end

endmodule

>>> design/four_variant_keystream_xor_cipher.sv
// four_variant_keystream_xor_cipher: top level of the keystream xor cipher
// depends on fvkxc_pkg, fvkxc_cfg_regs and fvkxc_keygen
//
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------
// input    | in_valid/in_ready  | data_in[7:0], message_id[31:0], last_in
// output   | out_valid/out_ready| data_out[7:0], last_out
// config   | cfg_we             | cfg_index[1:0], cfg_data[63:0]
//
// one word per cycle sustained while out_ready is high; a word lands in the
// input register at the edge that accepts it, moves on to the result register
// when that is free, and leaves from there while out_ready is high
// the keystream step runs between input register and result register and the
// generator state and position are written in the same cycle, so the next
// word sees them at once; the longest path is the lcg multiply-add
// reset clears configuration, position, generator state and both valid flags;
// nothing needs a clearing pass
// with out_ready low the result register holds, the input register fills
// behind it, then in_ready drops

module four_variant_keystream_xor_cipher
	import fvkxc_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_in,
	input  logic [31:0]               message_id,
	input  logic                      last_in,
	// output channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                data_out,
	output logic                      last_out,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t cfg;

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic [31:0] id_s1;
	logic        last_s1;

	// result register
	logic        valid_s2;
	logic [7:0]  data_s2;
	logic        last_s2;

	// per-message state
	logic [POSITION_BITS-1:0] pos_q;
	logic [STATE_BITS-1:0]    gen_q;
	logic                     in_msg_q;

	logic                  s2_free;
	logic                  advance;
	logic                  take_in;
	logic [7:0]            ks_byte;
	logic [STATE_BITS-1:0] gen_next;

	fvkxc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// keystream step for the word in the input register
	fvkxc_keygen #(
		.POSITION_BITS (POSITION_BITS)
	) u_keygen (
		.cfg       (cfg),
		.seed_now  (!in_msg_q),
		.gen_state (gen_q),
		.pos       (pos_q),
		.fid       (id_s1),
		.ks_byte   (ks_byte),
		.gen_next  (gen_next)
	);

	// result register can load when empty or being drained this cycle
	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= data_in;
			id_s1   <= message_id;
			last_s1 <= last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= data_s1 ^ ks_byte;
			last_s2 <= last_s1;
		end
	end

	// position and generator move on as each word leaves the input register;
	// the last word of a message sends both back to the start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			gen_q    <= '0;
			in_msg_q <= 1'b0;
		end else if (advance) begin
			gen_q <= gen_next;
			if (last_s1) begin
				pos_q    <= '0;
				in_msg_q <= 1'b0;
			end else begin
				pos_q    <= pos_q + POSITION_BITS'(1);
				in_msg_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign data_out  = data_s2;
	assign last_out  = last_s2;

endmodule

>>> design/fvkxc_checker.sv
// fvkxc_checker: port-level checks on the cipher's handshakes and word count
// depends on fvkxc_pkg only through the bound top level; bound below

module fvkxc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_out,
	input logic       last_out
);

	// words taken in but not yet delivered
	logic [2:0] flight_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else begin
			flight_q <= 3'(flight_q + {2'd0, in_take} - {2'd0, out_take});
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_out) && $stable(last_out))
		else $error("output word changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flight_q != 3'd0)
		else $error("output word with no input word behind it");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q == 3'd0 || flight_q == 3'd1 || flight_q == 3'd2)
		else $error("more words held than the two registers can carry");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q == 3'd0 |-> in_ready)
		else $error("empty block refuses input");

endmodule

bind four_variant_keystream_xor_cipher fvkxc_checker u_fvkxc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_out  (data_out),
	.last_out  (last_out)
);
